/* rtl/cdad_pkg.sv */
// Shared types, constants, microcode program and month table for the date adder.
`timescale 1ns / 1ps

package cdad_pkg;

   // Field widths of the transactions.
   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int OFFS_W  = 16;
   localparam int DOY_W   = 9;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 17;

   // Calendar constants.
   localparam logic [DOY_W-1:0]   DAYS_COMMON     = 9'd365;
   localparam logic [DOY_W-1:0]   DAYS_LEAP       = 9'd366;
   localparam logic [6:0]         R100_MAX        = 7'd99;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_MAX        = 16'hFFFF;

   // Reciprocal of one hundred, scaled by two to the power RECIP_SHIFT.
   localparam logic [16:0] RECIP_100   = 17'd83887;
   localparam int          RECIP_SHIFT = 23;
   localparam int          CENT_W      = 10;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

   typedef struct packed {
      logic [YEAR_W-1:0]         year_in;
      logic [MONTH_W-1:0]        month_in;
      logic [DAY_W-1:0]          day_in;
      logic signed [OFFS_W-1:0]  day_offset;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year_out;
      logic [MONTH_W-1:0] month_out;
      logic [DAY_W-1:0]   day_out;
      logic [DOY_W-1:0]   day_of_year;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   // Datapath operations selected by the control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_INIT,
      OP_ADD_MONTH,
      OP_ADD_OFFSET,
      OP_YEAR_DEC,
      OP_YEAR_INC,
      OP_SPLIT_START,
      OP_SPLIT_MONTH,
      OP_EMIT,
      OP_ERR_DATE,
      OP_ERR_RANGE
   } op_type;

   // Jump conditions tested by the sequencer.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_FIRE,
      C_BAD_DATE,
      C_MON_LT,
      C_NEG_OK,
      C_NEG,
      C_OVER_OK,
      C_OVER,
      C_SPLIT,
      C_OUT_BUSY
   } cond_type;

   // When the operation of a step is carried out.
   typedef enum logic [1:0] {
      RUN_ALWAYS,
      RUN_TAKEN,
      RUN_NOT_TAKEN
   } run_type;

   typedef logic [3:0] pc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      run_type  run;
      pc_type   target;
      pc_type   next;
   } uword_type;

   // Control from sequencer to datapath.
   typedef struct packed {
      op_type op;
      logic   en;
   } ctl_type;

   // Condition flags from datapath to sequencer.
   typedef struct packed {
      logic bad_date;
      logic mon_lt;
      logic neg_ok;
      logic neg;
      logic over_ok;
      logic over;
      logic split;
      logic out_busy;
   } flags_type;

   // Program addresses.
   localparam pc_type PC_IDLE      = 4'd0;
   localparam pc_type PC_INIT      = 4'd1;
   localparam pc_type PC_CHECK     = 4'd2;
   localparam pc_type PC_MONTHS    = 4'd3;
   localparam pc_type PC_OFFSET    = 4'd4;
   localparam pc_type PC_BACK      = 4'd5;
   localparam pc_type PC_BACK_CHK  = 4'd6;
   localparam pc_type PC_FWD       = 4'd7;
   localparam pc_type PC_FWD_CHK   = 4'd8;
   localparam pc_type PC_SPLIT0    = 4'd9;
   localparam pc_type PC_SPLIT     = 4'd10;
   localparam pc_type PC_EMIT      = 4'd11;
   localparam pc_type PC_ERR_DATE  = 4'd12;
   localparam pc_type PC_ERR_RANGE = 4'd13;

   // Microcode store: a condition hit jumps to target, otherwise to next.
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, run: RUN_ALWAYS, target: PC_IDLE, next: PC_IDLE};
      unique case (pc)
         PC_IDLE:      w = '{OP_LOAD, C_NO_FIRE, RUN_NOT_TAKEN, PC_IDLE, PC_INIT};
         PC_INIT:      w = '{OP_INIT, C_NEVER, RUN_ALWAYS, PC_IDLE, PC_CHECK};
         PC_CHECK:     w = '{OP_NOP, C_BAD_DATE, RUN_ALWAYS, PC_ERR_DATE, PC_MONTHS};
         PC_MONTHS:    w = '{OP_ADD_MONTH, C_MON_LT, RUN_TAKEN, PC_MONTHS, PC_OFFSET};
         PC_OFFSET:    w = '{OP_ADD_OFFSET, C_NEVER, RUN_ALWAYS, PC_IDLE, PC_BACK};
         PC_BACK:      w = '{OP_YEAR_DEC, C_NEG_OK, RUN_TAKEN, PC_BACK, PC_BACK_CHK};
         PC_BACK_CHK:  w = '{OP_NOP, C_NEG, RUN_ALWAYS, PC_ERR_RANGE, PC_FWD};
         PC_FWD:       w = '{OP_YEAR_INC, C_OVER_OK, RUN_TAKEN, PC_FWD, PC_FWD_CHK};
         PC_FWD_CHK:   w = '{OP_NOP, C_OVER, RUN_ALWAYS, PC_ERR_RANGE, PC_SPLIT0};
         PC_SPLIT0:    w = '{OP_SPLIT_START, C_NEVER, RUN_ALWAYS, PC_IDLE, PC_SPLIT};
         PC_SPLIT:     w = '{OP_SPLIT_MONTH, C_SPLIT, RUN_TAKEN, PC_SPLIT, PC_EMIT};
         PC_EMIT:      w = '{OP_EMIT, C_OUT_BUSY, RUN_NOT_TAKEN, PC_EMIT, PC_IDLE};
         PC_ERR_DATE:  w = '{OP_ERR_DATE, C_ALWAYS, RUN_ALWAYS, PC_EMIT, PC_EMIT};
         PC_ERR_RANGE: w = '{OP_ERR_RANGE, C_ALWAYS, RUN_ALWAYS, PC_EMIT, PC_EMIT};
         default:      w.op = OP_NOP;
      endcase
      return w;
   endfunction

   // Length of a month; months outside one to twelve have no days.
   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/calendar_date_add_days_unit.sv */
// Top level of the Gregorian date plus day offset unit.
// After acceptance the unit sums earlier months, adds the offset, steps years, splits months;
// a full 16-bit offset crosses up to 90 years; an impossible date skips to its error step.
// Throughput: one transaction at a time; the next is taken once the result is in the
// output register, which the year-stepping loop of the sequencer dominates.
// Reset: synchronous; the sequencer returns to its idle step and rsp_valid clears.
`timescale 1ns / 1ps

module calendar_date_add_days_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdad_pkg::rsp_type rsp_data
);

   cdad_pkg::ctl_type   ctl;
   cdad_pkg::flags_type flags;

   // Microcode sequencer.
   cdad_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .flags     (flags),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   // Datapath with the result register.
   cdad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // An accepted transaction moves the sequencer out of its idle step.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer stayed idle after a transaction");

   // Error results carry an all-zero date.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != cdad_pkg::ST_OK) |->
         (rsp_data.year_out == '0) && (rsp_data.month_out == '0) &&
         (rsp_data.day_out == '0) && (rsp_data.day_of_year == '0))
      else $error("error result with non-zero date fields");

   // Good results hold a real month, day and day of year.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cdad_pkg::ST_OK) |->
         (rsp_data.month_out != '0) && (rsp_data.month_out <= cdad_pkg::MONTHS_PER_YEAR) &&
         (rsp_data.day_out != '0) && (rsp_data.day_of_year < cdad_pkg::DAYS_LEAP))
      else $error("good result outside the calendar");

   // Status is one of the three defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == cdad_pkg::ST_OK) ||
                    (rsp_data.status == cdad_pkg::ST_BAD_DATE) ||
                    (rsp_data.status == cdad_pkg::ST_RANGE))
      else $error("undefined status code");

endmodule

/* rtl/cdad_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module cdad_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  cdad_pkg::flags_type flags,
   output logic                req_ready,
   output cdad_pkg::ctl_type   ctl
);

   cdad_pkg::pc_type    pc_ff;
   cdad_pkg::pc_type    pc_in;
   cdad_pkg::uword_type word;
   logic                hit;
   logic                run;

   // Fetch the control word and resolve its jump condition.
   always_comb begin
      word = cdad_pkg::ucode(pc_ff);
      unique case (word.cond)
         cdad_pkg::C_NEVER:    hit = 1'b0;
         cdad_pkg::C_ALWAYS:   hit = 1'b1;
         cdad_pkg::C_NO_FIRE:  hit = !req_valid;
         cdad_pkg::C_BAD_DATE: hit = flags.bad_date;
         cdad_pkg::C_MON_LT:   hit = flags.mon_lt;
         cdad_pkg::C_NEG_OK:   hit = flags.neg_ok;
         cdad_pkg::C_NEG:      hit = flags.neg;
         cdad_pkg::C_OVER_OK:  hit = flags.over_ok;
         cdad_pkg::C_OVER:     hit = flags.over;
         cdad_pkg::C_SPLIT:    hit = flags.split;
         cdad_pkg::C_OUT_BUSY: hit = flags.out_busy;
         default:              hit = 1'b0;
      endcase
      unique case (word.run)
         cdad_pkg::RUN_TAKEN:     run = hit;
         cdad_pkg::RUN_NOT_TAKEN: run = !hit;
         default:                 run = 1'b1;
      endcase
      pc_in = hit ? word.target : word.next;
   end

   // The block takes a transaction only at the load step.
   assign req_ready = (word.op == cdad_pkg::OP_LOAD);
   assign ctl       = '{op: word.op, en: run};

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= cdad_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* rtl/cdad_dp.sv */
// Datapath: date registers, leap tracking, day arithmetic and result register.
`timescale 1ns / 1ps

module cdad_dp (
   input  logic                clock,
   input  logic                reset,
   input  cdad_pkg::ctl_type   ctl,
   input  cdad_pkg::req_type   req_data,
   input  logic                rsp_ready,
   output cdad_pkg::flags_type flags,
   output logic                rsp_valid,
   output cdad_pkg::rsp_type   rsp_data
);

   logic [cdad_pkg::YEAR_W-1:0]         year_ff, year_in;
   logic [cdad_pkg::MONTH_W-1:0]        month_ff, month_in;
   logic [cdad_pkg::DAY_W-1:0]          day_ff, day_in;
   logic signed [cdad_pkg::OFFS_W-1:0]  offset_ff, offset_in;
   logic signed [cdad_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [cdad_pkg::MONTH_W-1:0]        mcnt_ff, mcnt_in;
   logic [cdad_pkg::CENT_W-1:0]         cent_ff, cent_in;
   logic [6:0]                          r100_ff, r100_in;
   logic [1:0]                          q4_ff, q4_in;
   logic [cdad_pkg::DOY_W-1:0]          doy_ff, doy_in;
   logic [cdad_pkg::STAT_W-1:0]         stat_ff, stat_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cdad_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [32:0]                  prod;
   logic [cdad_pkg::YEAR_W-1:0]  cent_x100;
   logic [cdad_pkg::YEAR_W-1:0]  rem_full;
   logic                         leap;
   logic                         leap_prev;
   logic [6:0]                   r100_prev;
   logic [1:0]                   q4_prev;
   logic [cdad_pkg::DOY_W-1:0]   ylen;
   logic [cdad_pkg::DOY_W-1:0]   ylen_prev;
   logic [cdad_pkg::DAY_W-1:0]   mlen_cur;
   logic [cdad_pkg::DAY_W-1:0]   mlen_start;

   // Century quotient of the incoming year by reciprocal multiplication.
   assign prod = 33'(req_data.year_in) * 33'(cdad_pkg::RECIP_100);

   // Remainder modulo one hundred from the registered quotient.
   assign cent_x100 = 16'({cent_ff, 6'd0}) + 16'({cent_ff, 5'd0}) + 16'({cent_ff, 2'd0});
   assign rem_full  = year_ff - cent_x100;

   // Leap rule for the current year and for the year before it.
   assign leap      = (year_ff[1:0] == 2'd0) && ((r100_ff != 7'd0) || (q4_ff == 2'd0));
   assign r100_prev = (r100_ff == 7'd0) ? cdad_pkg::R100_MAX : r100_ff - 7'd1;
   assign q4_prev   = (r100_ff == 7'd0) ? q4_ff - 2'd1 : q4_ff;
   assign leap_prev = (year_ff[1:0] == 2'd1) && ((r100_prev != 7'd0) || (q4_prev == 2'd0));
   assign ylen      = leap ? cdad_pkg::DAYS_LEAP : cdad_pkg::DAYS_COMMON;
   assign ylen_prev = leap_prev ? cdad_pkg::DAYS_LEAP : cdad_pkg::DAYS_COMMON;
   assign mlen_cur  = cdad_pkg::month_len(leap, mcnt_ff);
   assign mlen_start = cdad_pkg::month_len(leap, month_ff);

   // Condition flags for the sequencer.
   always_comb begin
      flags.bad_date = (month_ff == 4'd0) || (month_ff > cdad_pkg::MONTHS_PER_YEAR) ||
                       (day_ff == 5'd0) || (day_ff > mlen_start);
      flags.mon_lt   = (mcnt_ff < month_ff);
      flags.neg      = total_ff[cdad_pkg::TOTAL_W-1];
      flags.neg_ok   = flags.neg && (year_ff != 16'd0);
      flags.over     = !flags.neg && (total_ff[15:0] >= 16'(ylen));
      flags.over_ok  = flags.over && (year_ff != cdad_pkg::YEAR_MAX);
      flags.split    = (mcnt_ff < cdad_pkg::MONTHS_PER_YEAR) &&
                       (total_ff[15:0] >= 16'(mlen_cur));
      flags.out_busy = rsp_valid_ff && !rsp_ready;
   end

   // Operation decode.
   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      offset_in    = offset_ff;
      total_in     = total_ff;
      mcnt_in      = mcnt_ff;
      cent_in      = cent_ff;
      r100_in      = r100_ff;
      q4_in        = q4_ff;
      doy_in       = doy_ff;
      stat_in      = stat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.en) begin
         unique case (ctl.op)
            cdad_pkg::OP_LOAD: begin
               year_in   = req_data.year_in;
               month_in  = req_data.month_in;
               day_in    = req_data.day_in;
               offset_in = req_data.day_offset;
               total_in  = 17'(req_data.day_in) - 17'd1;
               mcnt_in   = 4'd1;
               cent_in   = prod[cdad_pkg::RECIP_SHIFT +: cdad_pkg::CENT_W];
               stat_in   = cdad_pkg::ST_OK;
            end
            cdad_pkg::OP_INIT: begin
               r100_in = rem_full[6:0];
               q4_in   = cent_ff[1:0];
            end
            cdad_pkg::OP_ADD_MONTH: begin
               total_in = total_ff + $signed(17'(mlen_cur));
               mcnt_in  = mcnt_ff + 4'd1;
            end
            cdad_pkg::OP_ADD_OFFSET: begin
               total_in = total_ff + $signed({offset_ff[cdad_pkg::OFFS_W-1], offset_ff});
            end
            cdad_pkg::OP_YEAR_DEC: begin
               year_in  = year_ff - 16'd1;
               r100_in  = r100_prev;
               q4_in    = q4_prev;
               total_in = total_ff + $signed(17'(ylen_prev));
            end
            cdad_pkg::OP_YEAR_INC: begin
               year_in  = year_ff + 16'd1;
               r100_in  = (r100_ff == cdad_pkg::R100_MAX) ? 7'd0 : r100_ff + 7'd1;
               q4_in    = (r100_ff == cdad_pkg::R100_MAX) ? q4_ff + 2'd1 : q4_ff;
               total_in = total_ff - $signed(17'(ylen));
            end
            cdad_pkg::OP_SPLIT_START: begin
               doy_in  = total_ff[cdad_pkg::DOY_W-1:0];
               mcnt_in = 4'd1;
            end
            cdad_pkg::OP_SPLIT_MONTH: begin
               total_in = total_ff - $signed(17'(mlen_cur));
               mcnt_in  = mcnt_ff + 4'd1;
            end
            cdad_pkg::OP_ERR_DATE: begin
               stat_in = cdad_pkg::ST_BAD_DATE;
            end
            cdad_pkg::OP_ERR_RANGE: begin
               stat_in = cdad_pkg::ST_RANGE;
            end
            cdad_pkg::OP_EMIT: begin
               rsp_valid_in = 1'b1;
               if (stat_ff == cdad_pkg::ST_OK) begin
                  rsp_in.year_out    = year_ff;
                  rsp_in.month_out   = mcnt_ff;
                  rsp_in.day_out     = total_ff[cdad_pkg::DAY_W-1:0] + 5'd1;
                  rsp_in.day_of_year = doy_ff;
               end else begin
                  rsp_in.year_out    = '0;
                  rsp_in.month_out   = '0;
                  rsp_in.day_out     = '0;
                  rsp_in.day_of_year = '0;
               end
               rsp_in.status = stat_ff;
            end
            default: begin
               stat_in = stat_ff;
            end
         endcase
      end
   end

   // Working registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      offset_ff <= offset_in;
      total_ff  <= total_in;
      mcnt_ff   <= mcnt_in;
      cent_ff   <= cent_in;
      r100_ff   <= r100_in;
      q4_ff     <= q4_in;
      doy_ff    <= doy_in;
      stat_ff   <= stat_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
